// ===== hdl/motor_speed_pi_controller_assert.svh =====
// Assertion macros for the motor speed controller.
// Each macro expects clk and rst_n to exist in the scope where it is used.
`ifndef MOTOR_SPEED_PI_CONTROLLER_ASSERT_SVH
`define MOTOR_SPEED_PI_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MSPC_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mspc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MSPC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mspc: next-cycle check failed");

`endif

// ===== hdl/mspc_pkg.sv =====
// Shared types and constants of the motor speed controller.
// Used by the sequencer, the multiply-accumulate unit and the top level.
package mspc_pkg;

    localparam int GAIN_FRAC_BITS = 16;
    localparam int SH             = GAIN_FRAC_BITS + 1;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KI     = 3'd4;

    localparam logic [1:0] MODE_BANG = 2'd0;
    localparam logic [1:0] MODE_PROP = 2'd1;
    localparam logic [1:0] MODE_PI   = 2'd2;

    localparam logic [31:0] TARGET_RST = 32'd10000;
    localparam logic [15:0] SCALE_RST  = 16'd50;
    localparam logic [15:0] KP_RST     = 16'd459;
    localparam logic [15:0] KI_RST     = 16'd66;

    localparam logic signed [7:0] DRIVE_MAX = 8'sd100;
    localparam logic signed [7:0] DRIVE_MIN = -8'sd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPEED_MUL,
        ST_SPEED_SAT,
        ST_ERR,
        ST_PROP_MUL,
        ST_INT_MUL,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_SPEED,
        MUL_PROP,
        MUL_INT
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctl_t;

    typedef struct packed {
        logic     in_ready;
        mac_ctl_t mac;
        mul_sel_t mul_sel;
        logic     speed_ld;
        logic     err_ld;
        logic     out_ld;
    } ctl_t;

endpackage

// ===== hdl/mspc_mac.sv =====
// Shared multiply-accumulate unit: one registered signed multiplier
// feeding a registered accumulator. Depends on mspc_pkg.
module mspc_mac
    import mspc_pkg::*;
(
    input  logic                       clk,
    input  mac_ctl_t                   ctl,
    input  logic signed [MUL_A_W-1:0]  op_a,
    input  logic signed [MUL_B_W-1:0]  op_b,
    input  logic signed [ACC_W-1:0]    base,
    output logic signed [PROD_W-1:0]   prod,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [PROD_W-1:0] mult;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    assign mult = op_a * op_b;

    always_comb
    begin
        prod_next = ctl.mul_en ? mult : prod_reg;
        case (ctl.acc_op)
            ACC_LOAD: acc_next = base + ACC_W'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ===== hdl/mspc_ctrl.sv =====
// Sequencer of the motor speed controller: steps one tick through the
// shared multiply-accumulate unit. Depends on mspc_pkg.
module mspc_ctrl
    import mspc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic is_pi,
    input  logic out_free,
    output ctl_t ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.mac.acc_op = ACC_HOLD;
        ctl.mul_sel    = MUL_SPEED;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SPEED_MUL;
                end
            end
            ST_SPEED_MUL:
            begin
                ctl.mac.mul_en = 1'b1;
                ctl.mul_sel    = MUL_SPEED;
                state_next     = ST_SPEED_SAT;
            end
            ST_SPEED_SAT:
            begin
                ctl.speed_ld = 1'b1;
                state_next   = ST_ERR;
            end
            ST_ERR:
            begin
                ctl.err_ld = 1'b1;
                state_next = ST_PROP_MUL;
            end
            ST_PROP_MUL:
            begin
                ctl.mac.mul_en = 1'b1;
                ctl.mul_sel    = MUL_PROP;
                state_next     = ST_INT_MUL;
            end
            ST_INT_MUL:
            begin
                // The proportional product lands in the accumulator while the
                // integral product is formed.
                ctl.mac.mul_en = 1'b1;
                ctl.mul_sel    = MUL_INT;
                ctl.mac.acc_op = ACC_LOAD;
                state_next     = ST_ACC;
            end
            ST_ACC:
            begin
                ctl.mac.acc_op = is_pi ? ACC_ADD : ACC_HOLD;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ctl.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/motor_speed_pi_controller.sv =====
// Top level of the motor speed controller: configuration registers,
// controller state, operand selection and output register.
// Depends on mspc_pkg, mspc_ctrl, mspc_mac and the assertion macro header.
//
// Usage:
// One slave beat on s_* carries an encoder count sample for one control tick.
// One master beat on m_* returns the drive command and the measured speed.
// The cfg_* channel writes a register by index (0 mode, 1 target speed,
// 2 speed scale, 3 proportional gain, 4 integral gain); it is always ready,
// and writes to other indexes are dropped. Write it only while no tick is
// in flight.
// A result is loaded into the output register in the last step of the
// sequence. All arithmetic runs in sequence through one 34 x 18 multiplier
// and one accumulator, so a new tick is accepted only after the previous
// result has been loaded into the output register.
// s_tready is high only while the sequencer is idle.
// If the receiver stalls, the finished result waits in the output register;
// the next tick is still accepted and worked, and it waits in its last step
// until the output register frees up.
// Reset (rst_n low) loads the register defaults, clears the stored count,
// error and drive, and empties the output register.
`include "motor_speed_pi_controller_assert.svh"

module motor_speed_pi_controller
    import mspc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // [31:0] encoder_count
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata,   // [7:0] drive, [39:8] measured_speed
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << SH) - 64'd1);
    localparam int               EXT_W      = ACC_W - 8 - SH;

    ctl_t ctl;

    logic [1:0]  mode_reg, mode_next;
    logic [31:0] target_reg, target_next;
    logic [15:0] scale_reg, scale_next;
    logic [15:0] kp_reg, kp_next;
    logic [15:0] ki_reg, ki_next;

    logic [31:0]       prev_count_reg, prev_count_next;
    logic signed [31:0] prev_err_reg, prev_err_next;
    logic signed [7:0]  prev_drive_reg, prev_drive_next;

    logic [31:0]        count_reg, count_next;
    logic signed [31:0] speed_reg, speed_next;
    logic signed [31:0] err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [7:0]  drive_out_reg, drive_out_next;
    logic [31:0]        speed_out_reg, speed_out_next;

    logic                      is_pi;
    logic                      out_free;
    logic [31:0]               diff;
    logic signed [32:0]        err_wide;
    logic signed [32:0]        err_ext, eo_ext, e_minus, e_plus;
    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [ACC_W-1:0]   base;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   biased, quot;
    logic signed [7:0]         drive_law, drive_val;
    logic signed [31:0]        speed_sat, err_sat;

    assign is_pi     = (mode_reg != MODE_BANG) && (mode_reg != MODE_PROP);
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = ctl.in_ready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {speed_out_reg, drive_out_reg};

    mspc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .is_pi    (is_pi),
        .out_free (out_free),
        .ctl      (ctl)
    );

    mspc_mac u_mac (
        .clk  (clk),
        .ctl  (ctl.mac),
        .op_a (op_a),
        .op_b (op_b),
        .base (base),
        .prod (prod),
        .acc  (acc)
    );

    // Operand selection for the shared multiplier.
    assign diff    = count_reg - prev_count_reg;
    assign err_ext = 33'(err_reg);
    assign eo_ext  = 33'(prev_err_reg);
    assign e_minus = err_ext - eo_ext;
    assign e_plus  = err_ext + eo_ext;

    always_comb
    begin
        case (ctl.mul_sel)
            MUL_SPEED:
            begin
                op_a = MUL_A_W'($signed(diff));
                op_b = $signed({2'b00, scale_reg});
            end
            MUL_PROP:
            begin
                // The proportional term is taken over 2^(F+1) like the integral term.
                op_a = is_pi ? MUL_A_W'(e_minus) : MUL_A_W'(err_reg);
                op_b = $signed({1'b0, kp_reg, 1'b0});
            end
            MUL_INT:
            begin
                op_a = MUL_A_W'(e_plus);
                op_b = $signed({2'b00, ki_reg});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign base = is_pi ? $signed({{EXT_W{prev_drive_reg[7]}}, prev_drive_reg, {SH{1'b0}}})
                        : '0;

    // Saturation of the speed product and of the error.
    assign speed_sat = (prod[PROD_W-1:31] == '0 || prod[PROD_W-1:31] == '1)
                     ? prod[31:0]
                     : (prod[PROD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
    assign err_wide  = 33'($signed(target_reg)) - 33'(speed_reg);
    assign err_sat   = (err_wide[32] == err_wide[31]) ? err_wide[31:0]
                     : (err_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    // Division by 2^(F+1) truncated toward zero, then the drive limits.
    assign biased = acc + (acc[ACC_W-1] ? $signed(ROUND_BIAS) : $signed(ACC_W'(0)));
    assign quot   = biased >>> SH;

    always_comb
    begin
        if (quot > ACC_W'(DRIVE_MAX))
        begin
            drive_law = DRIVE_MAX;
        end
        else if (quot < ACC_W'(DRIVE_MIN))
        begin
            drive_law = DRIVE_MIN;
        end
        else
        begin
            drive_law = quot[7:0];
        end
    end

    assign drive_val = (mode_reg == MODE_BANG)
                     ? (($signed(speed_reg) < $signed(target_reg)) ? DRIVE_MAX : 8'sd0)
                     : drive_law;

    always_comb
    begin
        mode_next       = mode_reg;
        target_next     = target_reg;
        scale_next      = scale_reg;
        kp_next         = kp_reg;
        ki_next         = ki_reg;
        prev_count_next = prev_count_reg;
        prev_err_next   = prev_err_reg;
        prev_drive_next = prev_drive_reg;
        out_valid_next  = out_valid_reg;
        count_next      = count_reg;
        speed_next      = speed_reg;
        err_next        = err_reg;
        drive_out_next  = drive_out_reg;
        speed_out_next  = speed_out_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:   mode_next   = cfg_data[1:0];
                REG_TARGET: target_next = cfg_data;
                REG_SCALE:  scale_next  = cfg_data[15:0];
                REG_KP:     kp_next     = cfg_data[15:0];
                REG_KI:     ki_next     = cfg_data[15:0];
                default:    ;
            endcase
        end

        if (s_tvalid && ctl.in_ready)
        begin
            count_next = s_tdata;
        end
        if (ctl.speed_ld)
        begin
            speed_next = speed_sat;
        end
        if (ctl.err_ld)
        begin
            err_next = err_sat;
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.out_ld)
        begin
            out_valid_next  = 1'b1;
            drive_out_next  = drive_val;
            speed_out_next  = speed_reg;
            prev_count_next = count_reg;
            prev_err_next   = err_reg;
            prev_drive_next = drive_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_PI;
            target_reg     <= TARGET_RST;
            scale_reg      <= SCALE_RST;
            kp_reg         <= KP_RST;
            ki_reg         <= KI_RST;
            prev_count_reg <= '0;
            prev_err_reg   <= '0;
            prev_drive_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            target_reg     <= target_next;
            scale_reg      <= scale_next;
            kp_reg         <= kp_next;
            ki_reg         <= ki_next;
            prev_count_reg <= prev_count_next;
            prev_err_reg   <= prev_err_next;
            prev_drive_reg <= prev_drive_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg     <= count_next;
        speed_reg     <= speed_next;
        err_reg       <= err_next;
        drive_out_reg <= drive_out_next;
        speed_out_reg <= speed_out_next;
    end

    `MSPC_ASSERT_IMPL(a_drive_range, m_tvalid, (drive_out_reg <= DRIVE_MAX) && (drive_out_reg >= DRIVE_MIN))
    `MSPC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `MSPC_ASSERT_NEXT(a_state_follows_result, ctl.out_ld, m_tvalid && (prev_drive_reg == drive_out_reg) && (prev_count_reg == $past(count_reg)))
    `MSPC_ASSERT_IMPL(a_no_load_when_full, ctl.out_ld, !out_valid_reg || m_tready)

endmodule
